// File: hdl/quaternion_rotate_vector_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion vector rotation block
// Checks compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define QRV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrv check failed");
// next-cycle implication
`define QRV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrv check failed");
`else
`define QRV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define QRV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// Widths, rounding constants and stage control type of the quaternion rotator.
// ----------------------------------------------------------------------------
package qrv_pkg;

    localparam int Q_W   = 16;   // Q2.14 quaternion component
    localparam int V_W   = 24;   // Q8.16 vector component
    localparam int SQ_W  = 2 * Q_W;
    localparam int PR_W  = Q_W + V_W;
    localparam int K_W   = SQ_W + 2;
    localparam int D_W   = PR_W + 2;
    localparam int C_W   = PR_W + 1;
    localparam int KV_W  = K_W + V_W;
    localparam int DU_W  = D_W + Q_W;
    localparam int WC_W  = C_W + Q_W;
    localparam int ACC_W = 60;
    localparam int FRAC_DROP = 28;
    localparam int QT_W  = ACC_W - FRAC_DROP;

    localparam int STAGES = 5;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_DROP - 1);
    localparam logic signed [QT_W-1:0]  OUT_MAX = QT_W'((1 <<< (V_W - 1)) - 1);
    localparam logic signed [QT_W-1:0]  OUT_MIN = -(QT_W'(1) <<< (V_W - 1));

    typedef struct packed {
        logic [STAGES-1:0] load;
    } stage_ctl_t;

endpackage

// File: hdl/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a Q8.16 vector by a Q2.14 quaternion: vector part of q * v * conj(q).
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: quat_x/y/z/w (Q2.14) and vec_x/y/z (Q8.16), taken when
//   in_valid is high and in_stall is low.
//   Output beat: rot_x/y/z (Q8.16, rounded half up, saturated to 24 bits),
//   taken when out_valid is high and out_stall is low.
//   Pipeline: a beat moves from the input to out_valid through the register
//   stages in order (products, sums, second products, accumulate, round/saturate).
//   Throughput: one beat per cycle while in_stall is low; each stage holds one beat.
//   A non-unit quaternion scales the result by |q|^2.
//   Reset clears all stage valid bits; no beat is in flight afterward.
//   When the receiver stalls, the output holds and stages behind it keep
//   filling empty slots; in_stall rises only once every stage is occupied.
// ----------------------------------------------------------------------------
`include "quaternion_rotate_vector_macros.svh"

module quaternion_rotate_vector (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [qrv_pkg::Q_W-1:0]   quat_x,
    input  logic signed [qrv_pkg::Q_W-1:0]   quat_y,
    input  logic signed [qrv_pkg::Q_W-1:0]   quat_z,
    input  logic signed [qrv_pkg::Q_W-1:0]   quat_w,
    input  logic signed [qrv_pkg::V_W-1:0]   vec_x,
    input  logic signed [qrv_pkg::V_W-1:0]   vec_y,
    input  logic signed [qrv_pkg::V_W-1:0]   vec_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [qrv_pkg::V_W-1:0]   rot_x,
    output logic signed [qrv_pkg::V_W-1:0]   rot_y,
    output logic signed [qrv_pkg::V_W-1:0]   rot_z
);
    import qrv_pkg::*;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES:0]   rdy;
    logic [STAGES-1:0] src_valid;
    logic              in_accept;
    stage_ctl_t        ctl;

    assign src_valid   = {valid_reg[STAGES-2:0], in_valid};

    always_comb
    begin
        rdy[STAGES] = !out_stall;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        for (int i = 0; i < STAGES; i++)
        begin
            ctl.load[i]   = rdy[i] && src_valid[i];
            valid_next[i] = rdy[i] ? src_valid[i] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign in_accept = in_valid && !in_stall;

    qrv_datapath u_datapath (
        .clk    (clk),
        .ctl    (ctl),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .quat_w (quat_w),
        .vec_x  (vec_x),
        .vec_y  (vec_y),
        .vec_z  (vec_z),
        .rot_x  (rot_x),
        .rot_y  (rot_y),
        .rot_z  (rot_z)
    );

    `QRV_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_accept, valid_reg[0])
    `QRV_ASSERT_NEXT(a_s1_moves_to_s2, clk, rst_n, valid_reg[0] && rdy[1], valid_reg[1])
    `QRV_ASSERT_NOW(a_full_stalls_input, clk, rst_n, (&valid_reg) && out_stall, in_stall)
    `QRV_ASSERT_NEXT(a_last_to_output, clk, rst_n, valid_reg[STAGES-2] && rdy[STAGES-1], out_valid)

endmodule

// File: hdl/qrv_datapath.sv
// ----------------------------------------------------------------------------
// qrv_datapath
// Five register stages: products, sums, second products, accumulate, round.
// ----------------------------------------------------------------------------
module qrv_datapath (
    input  logic                                 clk,
    input  qrv_pkg::stage_ctl_t                  ctl,
    input  logic signed [qrv_pkg::Q_W-1:0]       quat_x,
    input  logic signed [qrv_pkg::Q_W-1:0]       quat_y,
    input  logic signed [qrv_pkg::Q_W-1:0]       quat_z,
    input  logic signed [qrv_pkg::Q_W-1:0]       quat_w,
    input  logic signed [qrv_pkg::V_W-1:0]       vec_x,
    input  logic signed [qrv_pkg::V_W-1:0]       vec_y,
    input  logic signed [qrv_pkg::V_W-1:0]       vec_z,
    output logic signed [qrv_pkg::V_W-1:0]       rot_x,
    output logic signed [qrv_pkg::V_W-1:0]       rot_y,
    output logic signed [qrv_pkg::V_W-1:0]       rot_z
);
    import qrv_pkg::*;

    // stage 1: squares and first products
    logic signed [SQ_W-1:0] sxx_reg, syy_reg, szz_reg, sww_reg;
    logic signed [PR_W-1:0] pxvx_reg, pyvy_reg, pzvz_reg;
    logic signed [PR_W-1:0] pyvz_reg, pzvy_reg, pzvx_reg, pxvz_reg, pxvy_reg, pyvx_reg;
    logic signed [Q_W-1:0]  x1_reg, y1_reg, z1_reg, w1_reg;
    logic signed [V_W-1:0]  vx1_reg, vy1_reg, vz1_reg;

    // stage 2: k, dot, cross
    logic signed [K_W-1:0]  k_reg;
    logic signed [D_W-1:0]  d_reg;
    logic signed [C_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [Q_W-1:0]  x2_reg, y2_reg, z2_reg, w2_reg;
    logic signed [V_W-1:0]  vx2_reg, vy2_reg, vz2_reg;

    // stage 3: second products
    logic signed [KV_W-1:0] kvx_reg, kvy_reg, kvz_reg;
    logic signed [DU_W-1:0] dux_reg, duy_reg, duz_reg;
    logic signed [WC_W-1:0] wcx_reg, wcy_reg, wcz_reg;

    // stage 4: accumulate with rounding offset
    logic signed [ACC_W-1:0] accx_reg, accy_reg, accz_reg;
    logic signed [ACC_W-1:0] accx_next, accy_next, accz_next;

    // stage 5: shift and saturate
    logic signed [V_W-1:0]  rx_reg, ry_reg, rz_reg;
    logic signed [QT_W-1:0] qx, qy, qz;

    function automatic logic signed [V_W-1:0] sat24(input logic signed [QT_W-1:0] q);
        logic signed [V_W-1:0] r;
        if (q > OUT_MAX)
            r = OUT_MAX[V_W-1:0];
        else if (q < OUT_MIN)
            r = OUT_MIN[V_W-1:0];
        else
            r = q[V_W-1:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            sxx_reg  <= SQ_W'(quat_x) * SQ_W'(quat_x);
            syy_reg  <= SQ_W'(quat_y) * SQ_W'(quat_y);
            szz_reg  <= SQ_W'(quat_z) * SQ_W'(quat_z);
            sww_reg  <= SQ_W'(quat_w) * SQ_W'(quat_w);
            pxvx_reg <= PR_W'(quat_x) * PR_W'(vec_x);
            pyvy_reg <= PR_W'(quat_y) * PR_W'(vec_y);
            pzvz_reg <= PR_W'(quat_z) * PR_W'(vec_z);
            pyvz_reg <= PR_W'(quat_y) * PR_W'(vec_z);
            pzvy_reg <= PR_W'(quat_z) * PR_W'(vec_y);
            pzvx_reg <= PR_W'(quat_z) * PR_W'(vec_x);
            pxvz_reg <= PR_W'(quat_x) * PR_W'(vec_z);
            pxvy_reg <= PR_W'(quat_x) * PR_W'(vec_y);
            pyvx_reg <= PR_W'(quat_y) * PR_W'(vec_x);
            x1_reg   <= quat_x;
            y1_reg   <= quat_y;
            z1_reg   <= quat_z;
            w1_reg   <= quat_w;
            vx1_reg  <= vec_x;
            vy1_reg  <= vec_y;
            vz1_reg  <= vec_z;
        end
        if (ctl.load[1])
        begin
            k_reg   <= K_W'(sww_reg) - (K_W'(sxx_reg) + K_W'(syy_reg) + K_W'(szz_reg));
            d_reg   <= D_W'(pxvx_reg) + D_W'(pyvy_reg) + D_W'(pzvz_reg);
            cx_reg  <= C_W'(pyvz_reg) - C_W'(pzvy_reg);
            cy_reg  <= C_W'(pzvx_reg) - C_W'(pxvz_reg);
            cz_reg  <= C_W'(pxvy_reg) - C_W'(pyvx_reg);
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            w2_reg  <= w1_reg;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            vz2_reg <= vz1_reg;
        end
        if (ctl.load[2])
        begin
            kvx_reg <= KV_W'(k_reg) * KV_W'(vx2_reg);
            kvy_reg <= KV_W'(k_reg) * KV_W'(vy2_reg);
            kvz_reg <= KV_W'(k_reg) * KV_W'(vz2_reg);
            dux_reg <= DU_W'(d_reg) * DU_W'(x2_reg);
            duy_reg <= DU_W'(d_reg) * DU_W'(y2_reg);
            duz_reg <= DU_W'(d_reg) * DU_W'(z2_reg);
            wcx_reg <= WC_W'(cx_reg) * WC_W'(w2_reg);
            wcy_reg <= WC_W'(cy_reg) * WC_W'(w2_reg);
            wcz_reg <= WC_W'(cz_reg) * WC_W'(w2_reg);
        end
        if (ctl.load[3])
        begin
            accx_reg <= accx_next;
            accy_reg <= accy_next;
            accz_reg <= accz_next;
        end
        if (ctl.load[4])
        begin
            rx_reg <= sat24(qx);
            ry_reg <= sat24(qy);
            rz_reg <= sat24(qz);
        end
    end

    always_comb
    begin
        accx_next = ACC_W'(kvx_reg) + (ACC_W'(dux_reg) <<< 1) + (ACC_W'(wcx_reg) <<< 1)
                    + ROUND_HALF;
        accy_next = ACC_W'(kvy_reg) + (ACC_W'(duy_reg) <<< 1) + (ACC_W'(wcy_reg) <<< 1)
                    + ROUND_HALF;
        accz_next = ACC_W'(kvz_reg) + (ACC_W'(duz_reg) <<< 1) + (ACC_W'(wcz_reg) <<< 1)
                    + ROUND_HALF;
    end

    // floor division by 2^28 of the offset sum gives round half up
    assign qx = accx_reg[ACC_W-1:FRAC_DROP];
    assign qy = accy_reg[ACC_W-1:FRAC_DROP];
    assign qz = accz_reg[ACC_W-1:FRAC_DROP];

    assign rot_x = rx_reg;
    assign rot_y = ry_reg;
    assign rot_z = rz_reg;

endmodule
